### rtl/block_recursive_filter_with_prologue_macros.svh
// assertion macros for the recursive filter checker
`ifndef BLOCK_RECURSIVE_FILTER_WITH_PROLOGUE_MACROS_SVH
`define BLOCK_RECURSIVE_FILTER_WITH_PROLOGUE_MACROS_SVH

// clocked assertion, ignored while reset is held
`define RFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rfp assertion failed");

// clocked assertion that is also checked during reset
`define RFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rfp reset assertion failed");

`endif

### rtl/rfp_pkg.sv
// types and constants shared by the recursive filter files
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int unsigned PIX_W = 16;
  localparam int unsigned WGT_W = 17;

  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PROLOGUE = 2'd0;
  localparam mode_t MODE_SEED     = 2'd1;
  localparam mode_t MODE_FIRST    = 2'd2;
  localparam mode_t MODE_UNUSED   = 2'd3;

  typedef struct packed {
    mode_t             mode;
    logic              start_of_segment;
    logic              end_of_segment;
    logic [PIX_W-1:0]  pixel_red;
    logic [PIX_W-1:0]  pixel_green;
    logic [PIX_W-1:0]  pixel_blue;
    logic [WGT_W-1:0]  weight;
    logic [PIX_W-1:0]  seed_red;
    logic [PIX_W-1:0]  seed_green;
    logic [PIX_W-1:0]  seed_blue;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  out_red;
    logic [PIX_W-1:0]  out_green;
    logic [PIX_W-1:0]  out_blue;
    logic [WGT_W-1:0]  contribution;
    logic              segment_done;
  } out_item_t;

endpackage

### rtl/rfp_ifs.sv
// valid/ready channel interfaces for pixel and result transactions
`timescale 1ns / 1ps

interface rfp_in_if;
  logic              valid;
  logic              ready;
  rfp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfp_out_if;
  logic               valid;
  logic               ready;
  rfp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rfp_blend.sv
// one colour channel of the first-order recursion, fixed point
`timescale 1ns / 1ps

module rfp_blend (
  input  logic [rfp_pkg::PIX_W-1:0] x,
  input  logic [rfp_pkg::PIX_W-1:0] acc,
  input  logic [rfp_pkg::WGT_W-1:0] w,
  output logic [rfp_pkg::PIX_W-1:0] y
);

  // (1-w)*x + w*acc == x + w*(acc-x); the arithmetic shift gives the floor
  logic signed [rfp_pkg::PIX_W:0]   diff;
  logic signed [rfp_pkg::WGT_W:0]   w_s;
  logic signed [rfp_pkg::PIX_W+rfp_pkg::WGT_W+1:0] prod;
  logic signed [rfp_pkg::PIX_W+3:0] sum;

  always_comb begin
    diff = $signed({1'b0, acc}) - $signed({1'b0, x});
    w_s  = $signed({1'b0, w});
    prod = diff * w_s;
    sum  = $signed(prod[rfp_pkg::PIX_W+rfp_pkg::WGT_W+1:16])
         + $signed({4'b0000, x});
    if (sum < 0) begin
      y = '0;
    end else if (sum > $signed({4'b0000, rfp_pkg::PIX_MAX})) begin
      y = rfp_pkg::PIX_MAX;
    end else begin
      y = sum[rfp_pkg::PIX_W-1:0];
    end
  end

endmodule

### rtl/block_recursive_filter_with_prologue.sv
// recursive column filter with prologue pass, top level
`timescale 1ns / 1ps

// usage
//   in_chan  : one pixel transaction per column pixel, with mode, segment marks,
//              rgb sample, feedback weight and prologue seed colour
//   out_chan : filtered rgb, contribution and segment_done
//   mode 0 yields one result only on the pixel that ends the segment; modes 1
//   and 2 yield one result per pixel; mode 3 pixels are dropped silently
// timing
//   an accepted pixel lands in the input register; its result then moves into the
//   output register as soon as that register is free (empty or being read)
//   one pixel per cycle sustained while out_chan.ready is high; the feedback loop
//   is a single signed multiply-add per channel plus the weight-product multiply
// reset
//   synchronous active-low rst_n empties both registers, clears the colour
//   accumulators and sets the weight product to one
// stall
//   when out_chan.ready is low the result is held; the input register keeps
//   taking pixels that produce no result, and in_chan.ready drops once a
//   pixel with a result is waiting behind the held one
module block_recursive_filter_with_prologue (
  input logic      clk,
  input logic      rst_n,
  rfp_in_if.sink   in_chan,
  rfp_out_if.source out_chan
);

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  rfp_pkg::in_item_t s1_item_r;

  // recursion state
  logic [rfp_pkg::PIX_W-1:0] acc_red_r, acc_red_nxt;
  logic [rfp_pkg::PIX_W-1:0] acc_green_r, acc_green_nxt;
  logic [rfp_pkg::PIX_W-1:0] acc_blue_r, acc_blue_nxt;
  logic [rfp_pkg::WGT_W-1:0] wp_r, wp_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  rfp_pkg::out_item_t out_item_r, out_item_nxt;

  logic s1_used;
  logic s1_emits;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  logic [rfp_pkg::WGT_W-1:0] w_sat;
  logic [rfp_pkg::PIX_W-1:0] src_red, src_green, src_blue;
  logic [rfp_pkg::PIX_W-1:0] new_red, new_green, new_blue;
  logic [rfp_pkg::WGT_W-1:0] wp_src;
  logic [2*rfp_pkg::WGT_W-1:0] wp_prod;
  logic [rfp_pkg::WGT_W:0]   wp_shift;
  logic [rfp_pkg::WGT_W-1:0] wp_new;

  // which pixels touch the state and which produce a result
  always_comb begin
    case (s1_item_r.mode)
      rfp_pkg::MODE_PROLOGUE: begin
        s1_used  = 1'b1;
        s1_emits = s1_item_r.end_of_segment;
      end
      rfp_pkg::MODE_SEED, rfp_pkg::MODE_FIRST: begin
        s1_used  = 1'b1;
        s1_emits = 1'b1;
      end
      default: begin
        s1_used  = 1'b0;
        s1_emits = 1'b0;
      end
    endcase
  end

  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && (!s1_emits || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // weights above one are clipped to one
  assign w_sat = (s1_item_r.weight > rfp_pkg::ONE_Q16) ? rfp_pkg::ONE_Q16
                                                       : s1_item_r.weight;

  // recursion start value: state, or at segment start zero, seed or pixel by mode
  always_comb begin
    src_red   = acc_red_r;
    src_green = acc_green_r;
    src_blue  = acc_blue_r;
    wp_src    = wp_r;
    if (s1_item_r.start_of_segment) begin
      case (s1_item_r.mode)
        rfp_pkg::MODE_PROLOGUE: begin
          src_red   = '0;
          src_green = '0;
          src_blue  = '0;
          wp_src    = rfp_pkg::ONE_Q16;
        end
        rfp_pkg::MODE_SEED: begin
          src_red   = s1_item_r.seed_red;
          src_green = s1_item_r.seed_green;
          src_blue  = s1_item_r.seed_blue;
        end
        rfp_pkg::MODE_FIRST: begin
          src_red   = s1_item_r.pixel_red;
          src_green = s1_item_r.pixel_green;
          src_blue  = s1_item_r.pixel_blue;
        end
        default: begin
          src_red   = acc_red_r;
        end
      endcase
    end
  end

  rfp_blend u_blend_red (
    .x   (s1_item_r.pixel_red),
    .acc (src_red),
    .w   (w_sat),
    .y   (new_red)
  );

  rfp_blend u_blend_green (
    .x   (s1_item_r.pixel_green),
    .acc (src_green),
    .w   (w_sat),
    .y   (new_green)
  );

  rfp_blend u_blend_blue (
    .x   (s1_item_r.pixel_blue),
    .acc (src_blue),
    .w   (w_sat),
    .y   (new_blue)
  );

  // contribution: running product of the segment weights, truncated
  always_comb begin
    wp_prod  = wp_src * w_sat;
    wp_shift = wp_prod[2*rfp_pkg::WGT_W-1:16];
    if (wp_shift > {1'b0, rfp_pkg::ONE_Q16}) begin
      wp_new = rfp_pkg::ONE_Q16;
    end else begin
      wp_new = wp_shift[rfp_pkg::WGT_W-1:0];
    end
  end

  // state and register next values
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    acc_red_nxt   = acc_red_r;
    acc_green_nxt = acc_green_r;
    acc_blue_nxt  = acc_blue_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (in_chan.ready) begin
      s1_valid_nxt = in_chan.valid;
    end

    if (s1_fire && s1_used) begin
      acc_red_nxt   = new_red;
      acc_green_nxt = new_green;
      acc_blue_nxt  = new_blue;
      if (s1_item_r.mode == rfp_pkg::MODE_PROLOGUE) begin
        wp_nxt = wp_new;
      end
    end

    if (out_free) begin
      out_valid_nxt        = s1_valid_r && s1_emits;
      out_item_nxt.out_red   = new_red;
      out_item_nxt.out_green = new_green;
      out_item_nxt.out_blue  = new_blue;
      if (s1_item_r.mode == rfp_pkg::MODE_PROLOGUE) begin
        out_item_nxt.contribution = wp_new;
        out_item_nxt.segment_done = 1'b1;
      end else begin
        out_item_nxt.contribution = '0;
        out_item_nxt.segment_done = s1_item_r.end_of_segment;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_red_r   <= '0;
      acc_green_r <= '0;
      acc_blue_r  <= '0;
      wp_r        <= rfp_pkg::ONE_Q16;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      acc_red_r   <= acc_red_nxt;
      acc_green_r <= acc_green_nxt;
      acc_blue_r  <= acc_blue_nxt;
      wp_r        <= wp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_chan.data;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

endmodule

### rtl/rfp_checker.sv
// port-level assertions for the recursive filter, bound to the top level
`timescale 1ns / 1ps
`include "block_recursive_filter_with_prologue_macros.svh"

module rfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input rfp_pkg::out_item_t out_data
);

  // result channel comes up empty after reset
  `RFP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a stalled result stays offered and unchanged
  `RFP_ASSERT(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `RFP_ASSERT(a_hold_data, clk, rst_n, out_valid && !out_ready |=> $stable(out_data))

  // a nonzero contribution only comes from a prologue pass, which always ends a segment
  `RFP_ASSERT(a_contrib_done, clk, rst_n, out_valid && out_data.contribution != 0 |-> out_data.segment_done)

  // the weight product never exceeds one
  `RFP_ASSERT(a_contrib_max, clk, rst_n, out_valid |-> out_data.contribution <= rfp_pkg::ONE_Q16)

endmodule

bind block_recursive_filter_with_prologue rfp_checker u_rfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
